// File: rtl/graph_adjacency_degree_engine_defines.svh
// Assertion macros for the RTL, used by gade_ctrl
`ifndef GRAPH_ADJACENCY_DEGREE_ENGINE_DEFINES_SVH
`define GRAPH_ADJACENCY_DEGREE_ENGINE_DEFINES_SVH
`define GADE_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define GADE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// File: rtl/gade_pkg.sv
package gade_pkg;
    localparam int NODES_DEF = 32;
    localparam int CMD_W = 3;
    localparam int NODE_W = 6;
    localparam int DEG_W = 6;
    localparam int CHOSEN_W = 5;

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0, CMD_REMOVE = 3'd1, CMD_DROP_NODE = 3'd2, CMD_QUERY = 3'd3,
        CMD_PICK_MAX = 3'd4, CMD_PICK_MIN = 3'd5, CMD_PICK_DEG = 3'd6, CMD_SUMMARY = 3'd7
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [DEG_W-1:0]  wanted_degree;
    } t_req;

    typedef struct packed {
        logic              edge_present;
        logic [DEG_W-1:0]  node_degree;
        logic [CHOSEN_W-1:0] chosen_node;
        logic              chosen_found;
        logic [DEG_W-1:0]  largest_degree;
        logic [DEG_W-1:0]  active_count;
        logic              graph_empty;
        logic              graph_complete;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request
        logic clr_acc;    // start a scan pass
        logic row_step;   // process one (i,j) element, or refresh row i degree
        logic fin_node;   // close node i of a scan
        logic wr_edge;    // apply edge add/remove
        logic drop_step;  // clear column bit of node j, row of a at end
        logic fin_min;    // second pass of pick min and summary
        logic emit;       // build result
    } t_ctl;

    typedef struct packed {
        logic cmd_valid_nodes;
        logic [NODE_W:0] i_idx;
        logic [NODE_W:0] j_idx;
    } t_sts;
endpackage

// File: rtl/gade_if.sv
interface gade_req_if ();
    import gade_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gade_rsp_if ();
    import gade_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/graph_adjacency_degree_engine.sv
// A query goes straight to the result. Edge add/remove and remove node write the matrix, then
// refresh every degree (an out-of-range node skips to the result); pick max and pick degree scan
// the whole matrix, pick min and summary add a second pass over the nodes, with the single
// neighbour-sum accumulator stepping one matrix bit per cycle.
// One request at a time; the next is taken in the cycle after the result leaves.
// Reset (synchronous, active low) returns control to idle and clears the whole graph.
module graph_adjacency_degree_engine #(
    parameter int NODES = gade_pkg::NODES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gade_req_if.sink   i_req,
    gade_rsp_if.source o_rsp
);
    import gade_pkg::*;
    localparam int IW = $clog2(NODES);
    t_ctl ctl;
    logic [IW-1:0] row, col;
    logic va, vb;

    gade_ctrl #(.NODES(NODES)) u_ctrl (
        .i_clk, .i_rst_n, .i_req_valid(i_req.valid), .i_cmd(i_req.data.cmd),
        .i_va(va), .i_vb(vb), .i_rsp_ready(o_rsp.ready), .o_req_ready(i_req.ready),
        .o_rsp_valid(o_rsp.valid), .o_ctl(ctl), .o_row(row), .o_col(col)
    );
    gade_datapath #(.NODES(NODES)) u_dp (
        .i_clk, .i_rst_n, .i_req(i_req.data), .i_ctl(ctl), .i_row(row), .i_col(col),
        .o_rsp(o_rsp.data), .o_va(va), .o_vb(vb)
    );
endmodule

// File: rtl/gade_datapath.sv
module gade_datapath #(
    parameter int NODES = gade_pkg::NODES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gade_pkg::t_req  i_req,
    input  gade_pkg::t_ctl  i_ctl,
    input  logic [$clog2(NODES)-1:0] i_row,
    input  logic [$clog2(NODES)-1:0] i_col,
    output gade_pkg::t_rsp  o_rsp,
    output logic            o_va,
    output logic            o_vb
);
    import gade_pkg::*;
    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int SW = $clog2(NODES * NODES + 1);

    logic [NODES-1:0] r_adj [NODES];
    logic [CW-1:0]    r_deg [NODES];
    t_req             r_req;
    logic [SW-1:0]    r_sum;
    logic [IW-1:0]    r_best;
    logic [CW-1:0]    r_best_deg;
    logic [SW-1:0]    r_best_sum;
    logic             r_found;
    logic [CW-1:0]    r_maxd;
    logic [CW-1:0]    r_act;
    logic             r_cmpl;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic [IW-1:0] a_i, b_i;
    assign o_va = {1'b0, r_req.node_a} < (NODE_W+1)'(NODES);
    assign o_vb = {1'b0, r_req.node_b} < (NODE_W+1)'(NODES);
    assign a_i = IW'(r_req.node_a);
    assign b_i = IW'(r_req.node_b);

    // start each scan pass from zero so the first element counts
    logic [SW-1:0] sum_base;
    assign sum_base = i_ctl.clr_acc ? '0 : r_sum;
    logic [SW-1:0] sum_now;
    assign sum_now = r_adj[i_row][i_col] ? sum_base + SW'(r_deg[i_col]) : sum_base;
    logic [CW-1:0] d_i;
    assign d_i = r_deg[i_row];
    logic [CW-1:0] want_ext;
    assign want_ext = CW'(r_req.wanted_degree);
    logic want_ok;
    assign want_ok = {1'b0, r_req.wanted_degree} <= (DEG_W+1)'(NODES);

    always_comb begin
        n_rsp = '0;
        unique case (t_cmd'(r_req.cmd))
            CMD_QUERY: begin
                n_rsp.edge_present = o_va && o_vb && r_adj[a_i][b_i];
                n_rsp.node_degree = o_va ? DEG_W'(r_deg[a_i]) : '0;
            end
            CMD_PICK_MAX, CMD_PICK_MIN: begin
                n_rsp.chosen_node = CHOSEN_W'(r_best);
                n_rsp.chosen_found = 1'b1;
            end
            CMD_PICK_DEG: begin
                n_rsp.chosen_node = r_found ? CHOSEN_W'(r_best) : '0;
                n_rsp.chosen_found = r_found;
            end
            CMD_SUMMARY: begin
                n_rsp.largest_degree = DEG_W'(r_maxd);
                n_rsp.active_count = DEG_W'(r_act);
                n_rsp.graph_empty = (r_act == '0);
                n_rsp.graph_complete = r_cmpl;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) r_req <= i_req;
        if (i_ctl.fin_node) r_sum <= '0;
        else if (i_ctl.row_step) r_sum <= sum_now;
        else if (i_ctl.clr_acc) r_sum <= '0;
        if (i_ctl.clr_acc) begin
            r_best <= '0; r_best_deg <= '0; r_best_sum <= '0;
            r_found <= 1'b0; r_maxd <= '0; r_act <= '0; r_cmpl <= 1'b1;
        end
        if (i_ctl.fin_node) begin
            unique case (t_cmd'(r_req.cmd))
                CMD_PICK_MAX, CMD_PICK_MIN: begin
                    if (i_row == '0 || d_i > r_best_deg) begin
                        r_best <= i_row; r_best_deg <= d_i; r_best_sum <= sum_now;
                    end else if (d_i == r_best_deg && sum_now < r_best_sum) begin
                        r_best <= i_row; r_best_sum <= sum_now;
                    end
                end
                CMD_PICK_DEG: begin
                    if (want_ok && d_i == want_ext && (!r_found || sum_now < r_best_sum)) begin
                        r_found <= 1'b1; r_best <= i_row; r_best_sum <= sum_now;
                    end
                end
                default: begin
                    if (d_i > r_maxd) r_maxd <= d_i;
                    if (d_i != '0) r_act <= r_act + 1'b1;
                end
            endcase
        end
        if (i_ctl.fin_min) begin
            // second pass: r_best_deg holds current minimum
            if (i_row == '0) begin
                if (r_best_deg > CW'(1)) r_found <= 1'b1;
            end
            if ((r_found || (i_row == '0 && r_best_deg > CW'(1)))
                    && d_i != '0 && d_i < r_best_deg) begin
                r_best_deg <= d_i; r_best <= i_row;
            end
            // complete check for summary reuses this pass
            if (r_act > CW'(1) && d_i != '0 && d_i != r_act - 1'b1) r_cmpl <= 1'b0;
        end
        if (!i_rst_n) begin
            for (int k = 0; k < NODES; k++) begin
                r_adj[k] <= '0;
                r_deg[k] <= '0;
            end
        end else begin
            if (i_ctl.wr_edge) begin
                if (r_req.cmd == CMD_ADD) begin
                    r_adj[a_i][b_i] <= 1'b1;
                    if (a_i != b_i) r_adj[b_i][a_i] <= 1'b1;
                end else begin
                    r_adj[a_i][b_i] <= 1'b0;
                    if (a_i != b_i) r_adj[b_i][a_i] <= 1'b0;
                end
            end
            if (i_ctl.drop_step) begin
                // the row of a, self bit included, clears on the last column
                if (r_adj[a_i][i_col] && i_col != a_i) r_adj[i_col][a_i] <= 1'b0;
                if (i_col == IW'(NODES-1)) r_adj[a_i] <= '0;
            end
            // degree refresh of the row under the counter
            if (i_ctl.row_step && i_ctl.drop_step == 1'b0 && i_ctl.wr_edge == 1'b0
                    && i_ctl.fin_node == 1'b0 && r_req.cmd <= CMD_DROP_NODE) begin
                r_deg[i_row] <= CW'($countones(r_adj[i_row]));
            end
        end
        if (i_ctl.emit) r_rsp <= n_rsp;
    end
    assign o_rsp = r_rsp;
endmodule

// File: rtl/gade_ctrl.sv
`include "graph_adjacency_degree_engine_defines.svh"
module gade_ctrl #(
    parameter int NODES = gade_pkg::NODES_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    input  logic [gade_pkg::CMD_W-1:0] i_cmd,
    input  logic  i_va,
    input  logic  i_vb,
    input  logic  i_rsp_ready,
    output logic  o_req_ready,
    output logic  o_rsp_valid,
    output gade_pkg::t_ctl o_ctl,
    output logic [$clog2(NODES)-1:0] o_row,
    output logic [$clog2(NODES)-1:0] o_col
);
    import gade_pkg::*;
    localparam int IW = $clog2(NODES);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_EDGE = 8'b00000010, S_DROP = 8'b00000100,
        S_DEG  = 8'b00001000, S_SCAN = 8'b00010000, S_MIN = 8'b00100000,
        S_EMIT = 8'b01000000, S_OUT = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0] r_row, n_row, r_col, n_col;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic r_rsp_valid, n_rsp_valid;
    logic last_col, last_row;
    assign last_col = r_col == IW'(NODES-1);
    assign last_row = r_row == IW'(NODES-1);

    always_comb begin
        n_state = r_state; n_row = r_row; n_col = r_col; n_cmd = r_cmd;
        n_rsp_valid = r_rsp_valid;
        o_ctl = '0;
        if (r_rsp_valid && i_rsp_ready) n_rsp_valid = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_req_valid) begin
                o_ctl.load = 1'b1; n_cmd = i_cmd; n_row = '0; n_col = '0;
                unique case (t_cmd'(i_cmd))
                    CMD_ADD, CMD_REMOVE: n_state = S_EDGE;
                    CMD_DROP_NODE: n_state = S_DROP;
                    CMD_QUERY: n_state = S_EMIT;
                    default: n_state = S_SCAN;
                endcase
            end
            S_EDGE: begin
                if (i_va && i_vb) begin
                    o_ctl.wr_edge = 1'b1; n_state = S_DEG;
                end else n_state = S_EMIT;
            end
            S_DROP: begin
                if (!i_va) n_state = S_EMIT;
                else begin
                    o_ctl.drop_step = 1'b1; n_col = r_col + 1'b1;
                    if (last_col) begin n_col = '0; n_state = S_DEG; end
                end
            end
            S_DEG: begin
                // refresh every degree from its row
                o_ctl.row_step = 1'b1; n_row = r_row + 1'b1;
                if (last_row) begin n_row = '0; n_state = S_EMIT; end
            end
            S_SCAN: begin
                if (r_row == '0 && r_col == '0) o_ctl.clr_acc = 1'b1;
                o_ctl.row_step = 1'b1;
                n_col = r_col + 1'b1;
                if (last_col) begin
                    n_col = '0;
                    o_ctl.fin_node = 1'b1;
                    o_ctl.clr_acc = 1'b0;
                    n_row = r_row + 1'b1;
                    if (last_row) begin
                        n_row = '0;
                        n_state = (r_cmd == CMD_PICK_MIN || r_cmd == CMD_SUMMARY)
                                  ? S_MIN : S_EMIT;
                    end
                end
            end
            S_MIN: begin
                o_ctl.fin_min = 1'b1; n_row = r_row + 1'b1;
                if (last_row) begin n_row = '0; n_state = S_EMIT; end
            end
            S_EMIT: begin
                o_ctl.emit = 1'b1; n_rsp_valid = 1'b1; n_state = S_OUT;
            end
            S_OUT: if (!r_rsp_valid || i_rsp_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_EMIT && r_rsp_valid && !i_rsp_ready) begin
            o_ctl.emit = 1'b0; n_rsp_valid = 1'b1; n_state = S_EMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_rsp_valid <= 1'b0; r_row <= '0; r_col <= '0;
            r_cmd <= '0;
        end else begin
            r_state <= n_state; r_rsp_valid <= n_rsp_valid; r_row <= n_row;
            r_col <= n_col; r_cmd <= n_cmd;
        end
    end

    assign o_req_ready = r_state == S_IDLE;
    assign o_rsp_valid = r_rsp_valid;
    assign o_row = (r_state == S_DROP) ? r_col : r_row;
    assign o_col = r_col;

    `GADE_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_req_ready, !o_ctl.emit)
    `GADE_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, o_ctl.emit, r_rsp_valid)
    `GADE_ASSERT_IMPL(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
endmodule

// File: verif/graph_adjacency_degree_engine_test.sv
module graph_adjacency_degree_engine_test;
    import gade_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = NODES_DEF;
    localparam int RANDOM_ITEMS = 560;
    localparam int DRAIN_CYCLES = NODES * NODES + 4 * NODES + 16;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    gade_req_if req_if();
    gade_rsp_if rsp_if();

    graph_adjacency_degree_engine #(.NODES(NODES)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    bit [NODES-1:0] adj_rows [NODES];
    int unsigned    node_deg [NODES];
    t_rsp           rsp_due [$];
    int             mismatches;
    int             req_idle_pct;
    int             rsp_idle_pct;
    t_row           directed [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_req mk_req(t_cmd c, int a, int b, int w);
        t_req r;
        r.cmd = c;
        r.node_a = a[NODE_W-1:0];
        r.node_b = b[NODE_W-1:0];
        r.wanted_degree = w[DEG_W-1:0];
        return r;
    endfunction

    function automatic void recount(int n);
        node_deg[n] = $countones(adj_rows[n]);
    endfunction

    function automatic int unsigned neighbour_total(int n);
        int unsigned s;
        s = 0;
        for (int j = 0; j < NODES; j++)
            if (adj_rows[n][j]) s += node_deg[j];
        return s;
    endfunction

    function automatic int busiest_node();
        int best;
        int unsigned best_deg;
        int unsigned best_sum;
        int unsigned s;
        best = 0;
        best_deg = node_deg[0];
        best_sum = neighbour_total(0);
        for (int i = 1; i < NODES; i++) begin
            if (node_deg[i] == best_deg) begin
                s = neighbour_total(i);
                if (s < best_sum) begin
                    best = i;
                    best_sum = s;
                end
            end else if (node_deg[i] > best_deg) begin
                best = i;
                best_deg = node_deg[i];
                best_sum = neighbour_total(i);
            end
        end
        return best;
    endfunction

    // Apply one request to the graph copy and return the response it should give.
    function automatic t_rsp graph_apply(t_req r);
        t_rsp rsp;
        int a;
        int b;
        int w;
        int node;
        int unsigned mind;
        int unsigned s;
        int unsigned best_sum;
        int unsigned maxd;
        int unsigned act;
        bit va;
        bit vb;
        bit found;
        bit complete;
        rsp = '0;
        a = r.node_a;
        b = r.node_b;
        w = r.wanted_degree;
        va = a < NODES;
        vb = b < NODES;
        case (t_cmd'(r.cmd))
            CMD_ADD, CMD_REMOVE: begin
                if (va && vb) begin
                    adj_rows[a][b] = (r.cmd == CMD_ADD);
                    adj_rows[b][a] = (r.cmd == CMD_ADD);
                    recount(a);
                    recount(b);
                end
            end
            CMD_DROP_NODE: begin
                if (va) begin
                    for (int i = 0; i < NODES; i++)
                        if (adj_rows[a][i]) begin
                            adj_rows[i][a] = 1'b0;
                            recount(i);
                        end
                    adj_rows[a] = '0;
                    node_deg[a] = 0;
                end
            end
            CMD_QUERY: begin
                if (va && vb) rsp.edge_present = adj_rows[a][b];
                if (va) rsp.node_degree = node_deg[a][DEG_W-1:0];
            end
            CMD_PICK_MAX: begin
                node = busiest_node();
                rsp.chosen_node = node[CHOSEN_W-1:0];
                rsp.chosen_found = 1'b1;
            end
            CMD_PICK_MIN: begin
                node = busiest_node();
                mind = node_deg[node];
                if (mind > 1)
                    for (int i = 0; i < NODES; i++)
                        if (node_deg[i] < mind && node_deg[i] != 0) begin
                            mind = node_deg[i];
                            node = i;
                        end
                rsp.chosen_node = node[CHOSEN_W-1:0];
                rsp.chosen_found = 1'b1;
            end
            CMD_PICK_DEG: begin
                found = 1'b0;
                node = 0;
                best_sum = 0;
                for (int i = 0; i < NODES; i++)
                    if (node_deg[i] == w) begin
                        s = neighbour_total(i);
                        if (!found || s < best_sum) begin
                            found = 1'b1;
                            node = i;
                            best_sum = s;
                        end
                    end
                rsp.chosen_node = node[CHOSEN_W-1:0];
                rsp.chosen_found = found;
            end
            default: begin
                maxd = 0;
                act = 0;
                complete = 1'b1;
                for (int i = 0; i < NODES; i++) begin
                    if (node_deg[i] > maxd) maxd = node_deg[i];
                    if (node_deg[i] != 0) act++;
                end
                if (act > 1)
                    for (int i = 0; i < NODES; i++)
                        if (node_deg[i] != 0 && node_deg[i] != act - 1) complete = 1'b0;
                rsp.largest_degree = maxd[DEG_W-1:0];
                rsp.active_count = act[DEG_W-1:0];
                rsp.graph_empty = (act == 0);
                rsp.graph_complete = complete;
            end
        endcase
        return rsp;
    endfunction

    task automatic report(string field, int got, int want);
        $display("mismatch %s: got %0d, expected %0d", field, got, want);
        mismatches++;
    endtask

    // Hold the request until accepted, then queue its response.
    task automatic send(t_req r, bit typed, t_rsp typed_rsp);
        t_rsp predicted;
        if ($urandom_range(99) < req_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < req_idle_pct) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= r;
        do @(posedge i_clk); while (!req_if.ready);
        predicted = graph_apply(r);
        rsp_due.push_back(typed ? typed_rsp : predicted);
    endtask

    function automatic int rand_node();
        if ($urandom_range(99) < 12) return $urandom_range(63);
        return $urandom_range(NODES - 1);
    endfunction

    function automatic t_req random_req();
        int c;
        int w;
        c = $urandom_range(99);
        if ($urandom_range(1)) w = node_deg[$urandom_range(NODES - 1)];
        else w = $urandom_range(63);
        if (c < 30) return mk_req(CMD_ADD, rand_node(), rand_node(), w);
        if (c < 40) return mk_req(CMD_REMOVE, rand_node(), rand_node(), w);
        if (c < 45) return mk_req(CMD_DROP_NODE, rand_node(), rand_node(), w);
        if (c < 60) return mk_req(CMD_QUERY, rand_node(), rand_node(), w);
        if (c < 70) return mk_req(CMD_PICK_MAX, rand_node(), rand_node(), w);
        if (c < 80) return mk_req(CMD_PICK_MIN, rand_node(), rand_node(), w);
        if (c < 90) return mk_req(CMD_PICK_DEG, rand_node(), rand_node(), w);
        return mk_req(CMD_SUMMARY, rand_node(), rand_node(), w);
    endfunction

    always @(posedge i_clk) begin
        rsp_if.ready <= i_rst_n && ($urandom_range(99) >= rsp_idle_pct);
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (rsp_due.size() == 0) begin
                report("unexpected response", 1, 0);
            end else begin
                t_rsp want;
                t_rsp got;
                want = rsp_due.pop_front();
                got = rsp_if.data;
                if (got.edge_present !== want.edge_present)
                    report("edge_present", got.edge_present, want.edge_present);
                if (got.node_degree !== want.node_degree)
                    report("node_degree", got.node_degree, want.node_degree);
                if (got.chosen_node !== want.chosen_node)
                    report("chosen_node", got.chosen_node, want.chosen_node);
                if (got.chosen_found !== want.chosen_found)
                    report("chosen_found", got.chosen_found, want.chosen_found);
                if (got.largest_degree !== want.largest_degree)
                    report("largest_degree", got.largest_degree, want.largest_degree);
                if (got.active_count !== want.active_count)
                    report("active_count", got.active_count, want.active_count);
                if (got.graph_empty !== want.graph_empty)
                    report("graph_empty", got.graph_empty, want.graph_empty);
                if (got.graph_complete !== want.graph_complete)
                    report("graph_complete", got.graph_complete, want.graph_complete);
            end
        end
    end

    function automatic void add_row(t_req r, bit typed, t_rsp want);
        t_row row;
        row.req = r;
        row.typed = typed;
        row.want = want;
        directed.push_back(row);
    endfunction

    initial begin
        t_rsp zero;
        t_rsp k;
        t_req burst [$];
        int items;
        int waited;
        int members [$];
        zero = '0;
        mismatches = 0;
        req_idle_pct = 22;
        rsp_idle_pct = 77;
        for (int i = 0; i < NODES; i++) begin
            adj_rows[i] = '0;
            node_deg[i] = 0;
        end
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        k = zero; k.graph_empty = 1'b1; k.graph_complete = 1'b1;
        add_row(mk_req(CMD_SUMMARY, 0, 0, 0), 1, k);
        add_row(mk_req(CMD_QUERY, 0, 0, 0), 1, zero);
        k = zero; k.chosen_found = 1'b1;
        add_row(mk_req(CMD_PICK_MAX, 0, 0, 0), 1, k);
        add_row(mk_req(CMD_PICK_MIN, 0, 0, 0), 1, k);
        add_row(mk_req(CMD_PICK_DEG, 0, 0, 0), 1, k);
        add_row(mk_req(CMD_PICK_DEG, 0, 0, 63), 1, zero);
        add_row(mk_req(CMD_ADD, 63, 0, 0), 1, zero);
        add_row(mk_req(CMD_ADD, 0, 32, 0), 1, zero);
        add_row(mk_req(CMD_ADD, 5, 5, 0), 1, zero);
        add_row(mk_req(CMD_ADD, 0, 31, 0), 1, zero);
        add_row(mk_req(CMD_ADD, 31, 31, 0), 1, zero);
        add_row(mk_req(CMD_ADD, 1, 2, 0), 1, zero);
        add_row(mk_req(CMD_ADD, 2, 31, 0), 1, zero);
        add_row(mk_req(CMD_QUERY, 5, 5, 0), 0, zero);
        add_row(mk_req(CMD_QUERY, 31, 0, 0), 0, zero);
        add_row(mk_req(CMD_QUERY, 63, 0, 0), 1, zero);
        add_row(mk_req(CMD_QUERY, 31, 63, 0), 0, zero);
        add_row(mk_req(CMD_PICK_MAX, 0, 0, 0), 0, zero);
        add_row(mk_req(CMD_PICK_MIN, 0, 0, 0), 0, zero);
        add_row(mk_req(CMD_PICK_DEG, 0, 0, 1), 0, zero);
        add_row(mk_req(CMD_SUMMARY, 0, 0, 0), 0, zero);
        add_row(mk_req(CMD_REMOVE, 1, 2, 0), 1, zero);
        add_row(mk_req(CMD_REMOVE, 40, 2, 0), 1, zero);
        add_row(mk_req(CMD_DROP_NODE, 31, 0, 0), 1, zero);
        add_row(mk_req(CMD_DROP_NODE, 63, 0, 0), 1, zero);
        add_row(mk_req(CMD_SUMMARY, 0, 0, 0), 0, zero);

        foreach (directed[n]) send(directed[n].req, directed[n].typed, directed[n].want);

        items = 0;
        while (items < RANDOM_ITEMS) begin
            // bursts may step past a boundary, so switch on ranges
            if (items >= 2 * RANDOM_ITEMS / 3) begin
                req_idle_pct = 0;
                rsp_idle_pct = 0;
            end else if (items >= RANDOM_ITEMS / 3) begin
                req_idle_pct = 77;
                rsp_idle_pct = 22;
            end
            burst.delete();
            if ($urandom_range(29) == 0) begin
                // build a small clique so complete-graph and tie cases come up
                members.delete();
                repeat ($urandom_range(2, 6)) members.push_back($urandom_range(NODES - 1));
                foreach (members[x])
                    for (int y = x + 1; y < members.size(); y++)
                        burst.push_back(mk_req(CMD_ADD, members[x], members[y], 0));
                burst.push_back(mk_req(CMD_SUMMARY, 0, 0, 0));
                burst.push_back(mk_req(CMD_PICK_MAX, 0, 0, 0));
            end else begin
                burst.push_back(random_req());
            end
            foreach (burst[n]) send(burst[n], 0, zero);
            items += burst.size();
        end
        req_if.valid <= 1'b0;

        waited = 0;
        while (rsp_due.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && rsp_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/gade_pkg.sv
rtl/gade_if.sv
rtl/gade_datapath.sv
rtl/gade_ctrl.sv
rtl/graph_adjacency_degree_engine.sv
verif/graph_adjacency_degree_engine_test.sv
